FILE: src/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and codes for the timer table scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam logic [1:0] REQ_SCHEDULE = 2'd0;
  localparam logic [1:0] REQ_CANCEL   = 2'd1;
  localparam logic [1:0] REQ_STOP_ALL = 2'd2;
  localparam logic [1:0] REQ_CHECK    = 2'd3;

  localparam logic [2:0] KIND_SCHEDULED = 3'd0;
  localparam logic [2:0] KIND_CANCELLED = 3'd1;
  localparam logic [2:0] KIND_STOPPED   = 3'd2;
  localparam logic [2:0] KIND_FIRED     = 3'd3;
  localparam logic [2:0] KIND_NONE      = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_DELAY = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] now_ms;
    logic [31:0] period_ms;
    logic        repeat_mode;
    logic [31:0] owner_tag;
    logic [31:0] target_id;
  } tts_in_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [1:0]  status;
    logic [31:0] timer_ident;
    logic [31:0] elapsed_periods;
    logic [31:0] fired_tag;
    logic [4:0]  removed_count;
    logic        last_of_run;
  } tts_out_t;

  typedef struct packed {
    logic [31:0] ident;
    logic [31:0] period;
    logic        rep;
    logic [63:0] deadline;
    logic [31:0] tag;
  } tts_slot_t;

  typedef struct packed {
    logic load;
    logic sched;
    logic stop;
    logic eval;
    logic div_step;
    logic mul;
    logic upd;
    logic fin;
  } tts_cmd_t;

  typedef struct packed {
    logic [1:0] in_req;
    logic [1:0] req;
    logic       out_free;
    logic       scan_end;
    logic       expired;
    logic       div_last;
    logic       pend_v;
  } tts_sts_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCHED, S_STOP, S_RD, S_EVAL, S_DIV, S_MUL, S_UPD, S_FIN
  } tts_state_t;

endpackage

FILE: src/timer_table_scheduler.sv
// ----------------------------------------------------------------------------
// timer_table_scheduler
// Ordered table of software timers with schedule, cancel, stop-all and
// expiry check requests.
// ----------------------------------------------------------------------------
// One request is worked at a time. Schedule and stop-all need no table walk.
// Cancel and check walk the table through a single RAM read port, with a read
// state and an evaluate state per live timer; each expired timer adds a
// 64-step restoring divider that counts the missed periods, then a multiply
// and a deadline add. The table compacts in the same pass, so order is kept.
// Results leave through an output register; the next request is accepted
// while the last result waits.
module timer_table_scheduler #(
  parameter int MAX_TIMERS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tts_pkg::tts_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tts_pkg::tts_out_t out_data
);
  import tts_pkg::*;

  tts_cmd_t cmd;
  tts_sts_t sts;

  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tts_datapath #(.MAX_TIMERS(MAX_TIMERS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: src/tts_ram.sv
// ----------------------------------------------------------------------------
// tts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tts_ctrl.sv
// ----------------------------------------------------------------------------
// tts_ctrl
// Request sequencer: drives the table scan, divider and result emission.
// ----------------------------------------------------------------------------
module tts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tts_pkg::tts_sts_t sts,
  output tts_pkg::tts_cmd_t cmd
);
  import tts_pkg::*;

  tts_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (sts.in_req)
            REQ_SCHEDULE: state_nxt = S_SCHED;
            REQ_STOP_ALL: state_nxt = S_STOP;
            default:      state_nxt = S_RD;
          endcase
        end
      end
      S_SCHED: if (sts.out_free) state_nxt = S_IDLE;
      S_STOP:  if (sts.out_free) state_nxt = S_IDLE;
      S_RD:    state_nxt = sts.scan_end ? S_FIN : S_EVAL;
      S_EVAL: begin
        if (sts.req == REQ_CHECK && sts.expired) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_DIV:   if (sts.div_last) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_UPD;
      S_UPD:   if (!sts.pend_v || sts.out_free) state_nxt = S_RD;
      S_FIN:   if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCHED: cmd.sched    = sts.out_free;
      S_STOP:  cmd.stop     = sts.out_free;
      S_RD:    ;
      S_EVAL:  cmd.eval     = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_MUL:   cmd.mul      = 1'b1;
      S_UPD:   cmd.upd      = !sts.pend_v || sts.out_free;
      S_FIN:   cmd.fin      = sts.out_free;
      default: ;
    endcase
  end

endmodule

FILE: src/tts_datapath.sv
// ----------------------------------------------------------------------------
// tts_datapath
// Timer table storage, compaction pointers, divider, deadline update and
// result register.
// ----------------------------------------------------------------------------
module tts_datapath #(
  parameter int MAX_TIMERS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tts_pkg::tts_in_t  in_data,
  input  tts_pkg::tts_cmd_t cmd,
  output tts_pkg::tts_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output tts_pkg::tts_out_t out_data
);
  import tts_pkg::*;

  localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int SW = $bits(tts_slot_t);

  tts_in_t        req_r;
  logic [CW-1:0]  live_r, rd_r, wr_r;
  logic [31:0]    next_id_r;
  logic           found_r;
  logic           pend_v_r;
  tts_out_t       pend_r;
  tts_slot_t      slot_r;
  logic [63:0]    q_r;
  logic [31:0]    rem_r;
  logic [5:0]     cnt_r;
  logic [31:0]    elapsed_r;
  logic [63:0]    prod_r;
  logic           out_valid_r;
  tts_out_t       out_r;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  tts_slot_t      ram_wdata;
  logic [SW-1:0]  ram_rdata;
  tts_slot_t      rslot, new_slot, upd_slot;
  logic           out_free, sched_ok, is_match, keep;
  logic [32:0]    rem_sh;
  logic           ge;
  logic           sat;
  logic [31:0]    elapsed_c;
  logic           emit;
  tts_out_t       emit_data;

  tts_ram #(.WIDTH(SW), .DEPTH(MAX_TIMERS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rslot    = tts_slot_t'(ram_rdata);
  assign out_free = !out_valid_r || out_ready;
  assign sched_ok = cmd.sched && (req_r.period_ms != 32'd0) &&
                    (live_r != CW'(MAX_TIMERS));
  assign is_match = !found_r && (rslot.ident == req_r.target_id);
  assign keep     = (req_r.req_type == REQ_CHECK) ? !(req_r.now_ms >= rslot.deadline)
                                                  : !is_match;

  always_comb begin
    new_slot.ident    = next_id_r;
    new_slot.period   = req_r.period_ms;
    new_slot.rep      = req_r.repeat_mode;
    new_slot.deadline = req_r.now_ms + {32'd0, req_r.period_ms};
    new_slot.tag      = req_r.owner_tag;
    upd_slot          = slot_r;
    upd_slot.deadline = slot_r.deadline + prod_r;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_r[AW-1:0];
    ram_wdata = upd_slot;
    if (sched_ok) begin
      ram_we    = 1'b1;
      ram_waddr = live_r[AW-1:0];
      ram_wdata = new_slot;
    end else if (cmd.eval) begin
      ram_we    = keep;
      ram_wdata = rslot;
    end else if (cmd.upd) begin
      ram_we    = slot_r.rep;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh    = {rem_r, q_r[63]};
  assign ge        = rem_sh >= {1'b0, slot_r.period};
  assign sat       = (|q_r[63:32]) || (&q_r[31:0]);
  assign elapsed_c = sat ? 32'hFFFF_FFFF : q_r[31:0] + 32'd1;

  always_comb begin
    emit      = 1'b0;
    emit_data = '0;
    emit_data.last_of_run = 1'b1;
    if (cmd.sched) begin
      emit = 1'b1;
      emit_data.result_kind = KIND_SCHEDULED;
      if (req_r.period_ms == 32'd0) begin
        emit_data.status = ST_ZERO_DELAY;
      end else if (!sched_ok) begin
        emit_data.status = ST_FULL;
      end else begin
        emit_data.timer_ident = next_id_r;
      end
    end else if (cmd.stop) begin
      emit = 1'b1;
      emit_data.result_kind   = KIND_STOPPED;
      emit_data.removed_count = 5'(live_r);
    end else if (cmd.upd) begin
      emit      = pend_v_r;
      emit_data = pend_r;
    end else if (cmd.fin) begin
      emit = 1'b1;
      if (req_r.req_type == REQ_CANCEL) begin
        emit_data.result_kind = KIND_CANCELLED;
        if (found_r) begin
          emit_data.timer_ident = req_r.target_id;
        end else begin
          emit_data.status = ST_NOT_FOUND;
        end
      end else if (pend_v_r) begin
        emit_data = pend_r;
        emit_data.last_of_run = 1'b1;
      end else begin
        emit_data.result_kind = KIND_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      next_id_r   <= 32'd1;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      found_r     <= 1'b0;
      rd_r        <= '0;
      wr_r        <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        rd_r     <= '0;
        wr_r     <= '0;
        found_r  <= 1'b0;
        pend_v_r <= 1'b0;
      end
      if (sched_ok) begin
        live_r    <= live_r + CW'(1);
        next_id_r <= (next_id_r == 32'hFFFF_FFFF) ? 32'd1 : next_id_r + 32'd1;
      end
      if (cmd.stop) begin
        live_r <= '0;
      end
      if (cmd.eval) begin
        rd_r <= rd_r + CW'(1);
        if (keep) begin
          wr_r <= wr_r + CW'(1);
        end
        if (req_r.req_type == REQ_CANCEL && is_match) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.upd) begin
        pend_v_r <= 1'b1;
        if (slot_r.rep) begin
          wr_r <= wr_r + CW'(1);
        end
      end
      if (cmd.fin) begin
        live_r   <= wr_r;
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (emit) begin
      out_r <= emit_data;
    end
    if (cmd.eval) begin
      slot_r <= rslot;
      q_r    <= req_r.now_ms - rslot.deadline;
      rem_r  <= '0;
      cnt_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? 32'(rem_sh - {1'b0, slot_r.period}) : rem_sh[31:0];
      q_r   <= {q_r[62:0], ge};
      cnt_r <= cnt_r + 6'd1;
    end
    if (cmd.mul) begin
      elapsed_r <= elapsed_c;
      prod_r    <= {32'd0, slot_r.period} * {32'd0, elapsed_c};
    end
    if (cmd.upd) begin
      pend_r.result_kind     <= KIND_FIRED;
      pend_r.status          <= ST_OK;
      pend_r.timer_ident     <= slot_r.ident;
      pend_r.elapsed_periods <= elapsed_r;
      pend_r.fired_tag       <= slot_r.tag;
      pend_r.removed_count   <= '0;
      pend_r.last_of_run     <= 1'b0;
    end
  end

  always_comb begin
    sts.in_req   = in_data.req_type;
    sts.req      = req_r.req_type;
    sts.out_free = out_free;
    sts.scan_end = (rd_r == live_r);
    sts.expired  = req_r.now_ms >= rslot.deadline;
    sts.div_last = (cnt_r == 6'd63);
    sts.pend_v   = pend_v_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timer table scheduler: a behavioral model of
// the timer table predicts every result of each accepted request; results
// are compared field by field in order under random bursts and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tts_pkg::*;

  localparam int NSLOT = 16;
  localparam int WDOG_LIMIT = 200000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  tts_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  tts_out_t out_data;

  timer_table_scheduler #(.MAX_TIMERS(NSLOT)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  tts_slot_t tbl[NSLOT];
  int        tbl_cnt;
  logic [31:0] id_next;
  tts_out_t  expected_q[$];
  int        errors;
  int        idle_cycles;
  bit        hold_off;
  bit        stall_en;
  logic [31:0] issued_ids[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tts_out_t mk(logic [2:0] k, logic [1:0] s, logic [31:0] id,
                                  logic [31:0] tk, logic [31:0] tg, logic [4:0] rc,
                                  logic lst);
    tts_out_t r;
    r.result_kind = k; r.status = s; r.timer_ident = id; r.elapsed_periods = tk;
    r.fired_tag = tg; r.removed_count = rc; r.last_of_run = lst;
    return r;
  endfunction

  function automatic void queue_result(input tts_out_t r);
    expected_q = {expected_q, r};
  endfunction

  task automatic predict_timer_request(input tts_in_t q);
    int keep;
    int nfire;
    bit found;
    logic [63:0] missed;
    logic [31:0] ticks;
    tts_slot_t kept[NSLOT];
    case (q.req_type)
      REQ_SCHEDULE: begin
        if (q.period_ms == 0)
          queue_result(mk(KIND_SCHEDULED, ST_ZERO_DELAY, 0, 0, 0, 0, 1));
        else if (tbl_cnt >= NSLOT)
          queue_result(mk(KIND_SCHEDULED, ST_FULL, 0, 0, 0, 0, 1));
        else begin
          tbl[tbl_cnt] = '{id_next, q.period_ms, q.repeat_mode,
                           q.now_ms + {32'd0, q.period_ms}, q.owner_tag};
          tbl_cnt++;
          queue_result(mk(KIND_SCHEDULED, ST_OK, id_next, 0, 0, 0, 1));
          issued_ids = {issued_ids, id_next};
          id_next = id_next + 1;
          if (id_next == 0) id_next = 1;
        end
      end
      REQ_CANCEL: begin
        found = 0;
        for (int i = 0; i < tbl_cnt && !found; i++) begin
          if (tbl[i].ident == q.target_id) begin
            found = 1;
            for (int j = i; j + 1 < tbl_cnt; j++) tbl[j] = tbl[j + 1];
            tbl_cnt--;
          end
        end
        if (found) queue_result(mk(KIND_CANCELLED, ST_OK, q.target_id, 0, 0, 0, 1));
        else queue_result(mk(KIND_CANCELLED, ST_NOT_FOUND, 0, 0, 0, 0, 1));
      end
      REQ_STOP_ALL: begin
        queue_result(mk(KIND_STOPPED, ST_OK, 0, 0, 0, 5'(tbl_cnt), 1));
        tbl_cnt = 0;
      end
      default: begin
        keep = 0;
        nfire = 0;
        for (int i = 0; i < tbl_cnt; i++) begin
          if (q.now_ms >= tbl[i].deadline) begin
            missed = (q.now_ms - tbl[i].deadline) / {32'd0, tbl[i].period};
            ticks = (missed >= 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(missed + 1);
            queue_result(mk(KIND_FIRED, ST_OK, tbl[i].ident, ticks,
                            tbl[i].tag, 0, 0));
            nfire++;
            if (tbl[i].rep) begin
              tbl[i].deadline = tbl[i].deadline + {32'd0, tbl[i].period} * {32'd0, ticks};
              kept[keep++] = tbl[i];
            end
          end else
            kept[keep++] = tbl[i];
        end
        if (nfire == 0) queue_result(mk(KIND_NONE, ST_OK, 0, 0, 0, 0, 1));
        else expected_q[$].last_of_run = 1'b1;
        for (int i = 0; i < keep; i++) tbl[i] = kept[i];
        tbl_cnt = keep;
      end
    endcase
  endtask

  // sender: one request, then a random gap when the burst ends
  int burst_left;
  task automatic send_request(input tts_in_t q);
    int gap;
    in_valid <= 1'b1;
    in_data  <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_timer_request(q);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(12);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic tts_in_t req(logic [1:0] t, logic [63:0] now, logic [31:0] dly,
                                  logic rp, logic [31:0] tg, logic [31:0] tgt);
    tts_in_t q;
    q.req_type = t; q.now_ms = now; q.period_ms = dly; q.repeat_mode = rp;
    q.owner_tag = tg; q.target_id = tgt;
    return q;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_id();
    if (issued_ids.size() != 0 && $urandom_range(3) != 0)
      return issued_ids[$urandom_range(issued_ids.size() - 1)];
    return $urandom;
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else if (!stall_en) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(7) > 2);
  end

  always @(posedge clk) begin
    tts_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result kind=%0d", out_data.result_kind);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.result_kind !== e.result_kind) begin
          $error("result_kind exp %0d got %0d", e.result_kind, out_data.result_kind);
          errors++;
        end
        if (out_data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status); errors++;
        end
        if (out_data.timer_ident !== e.timer_ident) begin
          $error("timer_ident exp %0h got %0h", e.timer_ident, out_data.timer_ident);
          errors++;
        end
        if (out_data.elapsed_periods !== e.elapsed_periods) begin
          $error("elapsed_periods exp %0h got %0h", e.elapsed_periods,
                 out_data.elapsed_periods);
          errors++;
        end
        if (out_data.fired_tag !== e.fired_tag) begin
          $error("fired_tag exp %0h got %0h", e.fired_tag, out_data.fired_tag); errors++;
        end
        if (out_data.removed_count !== e.removed_count) begin
          $error("removed_count exp %0d got %0d", e.removed_count, out_data.removed_count);
          errors++;
        end
        if (out_data.last_of_run !== e.last_of_run) begin
          $error("last_of_run exp %0d got %0d", e.last_of_run, out_data.last_of_run);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(req(REQ_CHECK, 64'd0, 0, 0, 0, 0));
    send_request(req(REQ_SCHEDULE, 64'd5, 32'd0, 1, 32'hAAAA_5555, 0));
    send_request(req(REQ_SCHEDULE, 64'd0, 32'd1, 1, 32'hFFFF_FFFF, 0));
    send_request(req(REQ_SCHEDULE, 64'hFFFF_FFFF_FFFF_FFF0, 32'hFFFF_FFFF, 0, 32'h0, 0));
    send_request(req(REQ_SCHEDULE, 64'd100, 32'd10, 0, 32'h1234, 0));
    send_request(req(REQ_SCHEDULE, 64'd100, 32'd10, 1, 32'h5678, 0));
    send_request(req(REQ_CANCEL, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_request(req(REQ_CANCEL, 0, 0, 0, 0, 32'd0));
    send_request(req(REQ_CHECK, 64'd109, 0, 0, 0, 0));
    send_request(req(REQ_CHECK, 64'd155, 0, 0, 0, 0));
    send_request(req(REQ_CANCEL, 0, 0, 0, 0, 32'd4));
    send_request(req(REQ_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      send_request(req(REQ_SCHEDULE, 64'd1000, 32'(i + 1), i[0], $urandom, 0));
    send_request(req(REQ_STOP_ALL, 0, 0, 0, 0, 0));
    send_request(req(REQ_STOP_ALL, 0, 0, 0, 0, 0));
    release_input();
    drain();
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 24; i++)
          send_request(req(2'($urandom_range(3)), 64'($urandom_range(200)),
                           $urandom_range(50), 1'($urandom_range(1)), $urandom,
                           pick_id()));
        release_input();
      end
    join
    drain();
  endtask

  // tick-driven sequences: a clock advances, timers are scheduled, cancelled, stopped and checked
  task automatic test_random(input int n);
    logic [63:0] t;
    int r;
    t = 64'($urandom_range(1000));
    for (int i = 0; i < n; i++) begin
      stall_en = (i % 120) < 80;
      r = $urandom_range(99);
      if (r < 8) t = rnd64();
      else t = t + 64'($urandom_range(40));
      if (r < 40)
        send_request(req(REQ_SCHEDULE, t,
                         ($urandom_range(15) == 0) ? $urandom :
                         ($urandom_range(9) == 0 ? 32'd0 : 32'($urandom_range(60))),
                         1'($urandom_range(1)), $urandom, $urandom));
      else if (r < 55)
        send_request(req(REQ_CANCEL, rnd64(), $urandom, 1'($urandom_range(1)), $urandom,
                         pick_id()));
      else if (r < 59)
        send_request(req(REQ_STOP_ALL, rnd64(), $urandom, 1'($urandom_range(1)), $urandom,
                         $urandom));
      else
        send_request(req(REQ_CHECK, ($urandom_range(30) == 0) ? rnd64() : t, $urandom,
                         1'($urandom_range(1)), $urandom, $urandom));
    end
    release_input();
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_off = 1'b0;
    stall_en = 1'b1;
    errors = 0;
    idle_cycles = 0;
    tbl_cnt = 0;
    id_next = 32'd1;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(410);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
src/tts_pkg.sv
src/tts_ram.sv
src/tts_ctrl.sv
src/tts_datapath.sv
src/timer_table_scheduler.sv
tb/sv/tb.sv
